// ===== hdl/vco_pkg.sv =====
// ----------------------------------------------------------------------------
// vco_pkg
// Shared constants and neighbor pick tables for the voxel corner occlusion
// block.
// ----------------------------------------------------------------------------
package vco_pkg;

  localparam int NumNeighbors = 27;
  localparam int NumFaces     = 6;
  localparam int NumCorners   = 4;
  localparam int ShadeW       = 4;
  localparam int IdxW         = 5;
  localparam int FaceW        = 3;
  localparam int CornerW      = 5;

  localparam logic [FaceW-1:0]  FaceLast  = 3'd5;
  localparam logic [ShadeW-1:0] MaxShade  = 4'd8;
  localparam logic [CornerW-1:0] MaxCorner = 5'd31;

  typedef logic [IdxW-1:0] nbr_idx_t;

  // Per face and corner: the corner neighbor, then the two side neighbors.
  localparam nbr_idx_t SolidPick [NumFaces][NumCorners][3] = '{
    '{'{5'd0,  5'd1,  5'd3},  '{5'd2,  5'd1,  5'd5},
      '{5'd6,  5'd3,  5'd7},  '{5'd8,  5'd5,  5'd7}},
    '{'{5'd18, 5'd19, 5'd21}, '{5'd20, 5'd19, 5'd23},
      '{5'd24, 5'd21, 5'd25}, '{5'd26, 5'd23, 5'd25}},
    '{'{5'd6,  5'd7,  5'd15}, '{5'd8,  5'd7,  5'd17},
      '{5'd24, 5'd15, 5'd25}, '{5'd26, 5'd17, 5'd25}},
    '{'{5'd0,  5'd1,  5'd9},  '{5'd2,  5'd1,  5'd11},
      '{5'd18, 5'd9,  5'd19}, '{5'd20, 5'd11, 5'd19}},
    '{'{5'd0,  5'd3,  5'd9},  '{5'd6,  5'd3,  5'd15},
      '{5'd18, 5'd9,  5'd21}, '{5'd24, 5'd15, 5'd21}},
    '{'{5'd2,  5'd5,  5'd11}, '{5'd8,  5'd5,  5'd17},
      '{5'd20, 5'd11, 5'd23}, '{5'd26, 5'd17, 5'd23}}
  };

  // Per face and corner: the four neighbors whose shades are summed.
  localparam nbr_idx_t ShadePick [NumFaces][NumCorners][4] = '{
    '{'{5'd0,  5'd1,  5'd3,  5'd4},  '{5'd1,  5'd2,  5'd4,  5'd5},
      '{5'd3,  5'd4,  5'd6,  5'd7},  '{5'd4,  5'd5,  5'd7,  5'd8}},
    '{'{5'd18, 5'd19, 5'd21, 5'd22}, '{5'd19, 5'd20, 5'd22, 5'd23},
      '{5'd21, 5'd22, 5'd24, 5'd25}, '{5'd22, 5'd23, 5'd25, 5'd26}},
    '{'{5'd6,  5'd7,  5'd15, 5'd16}, '{5'd7,  5'd8,  5'd16, 5'd17},
      '{5'd15, 5'd16, 5'd24, 5'd25}, '{5'd16, 5'd17, 5'd25, 5'd26}},
    '{'{5'd0,  5'd1,  5'd9,  5'd10}, '{5'd1,  5'd2,  5'd10, 5'd11},
      '{5'd9,  5'd10, 5'd18, 5'd19}, '{5'd10, 5'd11, 5'd19, 5'd20}},
    '{'{5'd0,  5'd3,  5'd9,  5'd12}, '{5'd3,  5'd6,  5'd12, 5'd15},
      '{5'd9,  5'd12, 5'd18, 5'd21}, '{5'd12, 5'd15, 5'd21, 5'd24}},
    '{'{5'd2,  5'd5,  5'd11, 5'd14}, '{5'd5,  5'd8,  5'd14, 5'd17},
      '{5'd11, 5'd14, 5'd20, 5'd23}, '{5'd14, 5'd17, 5'd23, 5'd26}}
  };

endpackage

// ===== hdl/voxel_corner_occlusion_top.sv =====
// ----------------------------------------------------------------------------
// voxel_corner_occlusion_top
// Per-vertex ambient occlusion for the six faces of one voxel.
// ----------------------------------------------------------------------------
// Usage:
//   An input beat carries the 3x3x3 neighborhood of one block: a solid mask
//   and a 4-bit sky shade per neighbor. It is taken at a rising edge where
//   start is high and busy is low. The block then emits six result beats,
//   one per face in order 0..5, each on the result ports for exactly one
//   cycle with out_strobe_o high; last_face_o marks the sixth beat.
//   Timing: the accepting edge loads the input register and the face
//   counter, and the result register then puts face 0 on the result ports;
//   the following faces come on consecutive cycles.
//   Throughput: the face counter walks the held item one face per cycle,
//   so busy drops during the cycle in which the last face is computed and
//   the next item can be taken at that edge, giving an unbroken stream of
//   result beats.
//   The receiver cannot stall; results are never held back.
//   Reset (rst_ni low, asynchronous) clears the item valid flag, the face
//   counter and the strobe; any item in flight is dropped.
// ----------------------------------------------------------------------------
module voxel_corner_occlusion_top
  import vco_pkg::*;
(
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [NumNeighbors-1:0]           solid_mask_i,
  input  logic [63:0]                       shade_low_i,
  input  logic [43:0]                       shade_high_i,
  output logic                              out_strobe_o,
  output logic [FaceW-1:0]                  face_o,
  output logic [CornerW-1:0]                corner_a_o,
  output logic [CornerW-1:0]                corner_b_o,
  output logic [CornerW-1:0]                corner_c_o,
  output logic [CornerW-1:0]                corner_d_o,
  output logic                              last_face_o
);

  logic                                  accept;
  logic                                  valid_q;
  logic [FaceW-1:0]                      face_q;
  logic [NumNeighbors-1:0]               solid_q;
  logic [NumNeighbors*ShadeW-1:0]        shade_q;

  logic [NumCorners-1:0][CornerW-1:0]    corner_val;
  logic                                  strobe_q;
  logic [FaceW-1:0]                      face_out_q;
  logic [NumCorners-1:0][CornerW-1:0]    corner_out_q;

  // Busy while the held item still has faces to go after this cycle.
  assign busy   = valid_q && (face_q != FaceLast);
  assign accept = start && !busy;

  // Control: item valid flag and face counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      face_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= valid_q;
      if (accept) begin
        valid_q <= 1'b1;
        face_q  <= '0;
      end else if (valid_q) begin
        if (face_q == FaceLast) begin
          valid_q <= 1'b0;
        end else begin
          face_q <= face_q + 1'b1;
        end
      end
    end
  end

  // Input register: the neighborhood stays put for all six faces.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      solid_q <= solid_mask_i;
      shade_q <= {shade_high_i, shade_low_i};
    end
  end

  // One corner unit per corner; the face counter picks the table row.
  for (genvar c = 0; c < NumCorners; c++) begin : g_corner
    logic [2:0]              solid_sel;
    logic [3:0][ShadeW-1:0]  shade_sel;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        solid_sel[k] = solid_q[SolidPick[face_q][c][k]];
      end
      for (int k = 0; k < 4; k++) begin
        shade_sel[k] = shade_q[{ShadePick[face_q][c][k], 2'b00} +: ShadeW];
      end
    end

    vco_corner u_corner (
      .solid_i (solid_sel),
      .shade_i (shade_sel),
      .value_o (corner_val[c])
    );
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      face_out_q   <= face_q;
      corner_out_q <= corner_val;
    end
  end

  assign out_strobe_o = strobe_q;
  assign face_o       = face_out_q;
  assign corner_a_o   = corner_out_q[0];
  assign corner_b_o   = corner_out_q[1];
  assign corner_c_o   = corner_out_q[2];
  assign corner_d_o   = corner_out_q[3];
  assign last_face_o  = (face_out_q == FaceLast);

endmodule

// ===== hdl/vco_corner.sv =====
// ----------------------------------------------------------------------------
// vco_corner
// Occlusion value of one face corner from three solid bits and four shades.
// ----------------------------------------------------------------------------
module vco_corner
  import vco_pkg::*;
(
  input  logic [2:0]                   solid_i,  // {side2, side1, corner}
  input  logic [3:0][ShadeW-1:0]       shade_i,
  output logic [CornerW-1:0]           value_o
);

  logic [1:0]            count;
  logic [3:0][3:0]       shade_clamped;
  logic [5:0]            shade_total;
  logic [5:0]            total;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      shade_clamped[k] = (shade_i[k] > MaxShade) ? MaxShade : shade_i[k];
    end
  end

  // Both sides solid fully occlude the corner regardless of the diagonal.
  assign count = (solid_i[1] && solid_i[2]) ? 2'd3 :
                 2'({1'b0, solid_i[0]} + {1'b0, solid_i[1]} + {1'b0, solid_i[2]});

  assign shade_total = {2'b00, shade_clamped[0]} + {2'b00, shade_clamped[1]}
                     + {2'b00, shade_clamped[2]} + {2'b00, shade_clamped[3]};
  assign total     = {1'b0, count, 3'b000} + shade_total;
  assign value_o   = (total > {1'b0, MaxCorner}) ? MaxCorner : total[CornerW-1:0];

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for voxel_corner_occlusion_top. A directed table of
// neighborhoods is walked first (all-empty, all-solid, shade clamping,
// saturation, side-only and corner-only masks), some rows with the result
// typed in and the rest predicted. It is followed by random neighborhoods
// sent in bursts with random gaps. Every result beat is compared with a
// queue of predicted faces.
// ----------------------------------------------------------------------------
module testbench
  import vco_pkg::*;
();

  localparam int ClkPeriod    = 10;
  localparam int ResetCycles  = 9;
  localparam int RandomItems  = 140;
  localparam int SettleCycles = 8;
  localparam int TimeoutNs    = 2_000_000;
  localparam int ShadeBits    = NumNeighbors * ShadeW;

  // The bench keeps its own copy of the neighbor tables. It does not take
  // them from the package, so that an error in the package shows up as a
  // mismatch. Corner neighbor first, then the two side neighbors.
  localparam int CornerNbr [NumFaces][NumCorners][3] = '{
    '{'{0, 1, 3},    '{2, 1, 5},    '{6, 3, 7},    '{8, 5, 7}},
    '{'{18, 19, 21}, '{20, 19, 23}, '{24, 21, 25}, '{26, 23, 25}},
    '{'{6, 7, 15},   '{8, 7, 17},   '{24, 15, 25}, '{26, 17, 25}},
    '{'{0, 1, 9},    '{2, 1, 11},   '{18, 9, 19},  '{20, 11, 19}},
    '{'{0, 3, 9},    '{6, 3, 15},   '{18, 9, 21},  '{24, 15, 21}},
    '{'{2, 5, 11},   '{8, 5, 17},   '{20, 11, 23}, '{26, 17, 23}}
  };

  // The four neighbors whose sky shades add into each corner.
  localparam int ShadeNbr [NumFaces][NumCorners][4] = '{
    '{'{0, 1, 3, 4},     '{1, 2, 4, 5},     '{3, 4, 6, 7},     '{4, 5, 7, 8}},
    '{'{18, 19, 21, 22}, '{19, 20, 22, 23}, '{21, 22, 24, 25}, '{22, 23, 25, 26}},
    '{'{6, 7, 15, 16},   '{7, 8, 16, 17},   '{15, 16, 24, 25}, '{16, 17, 25, 26}},
    '{'{0, 1, 9, 10},    '{1, 2, 10, 11},   '{9, 10, 18, 19},  '{10, 11, 19, 20}},
    '{'{0, 3, 9, 12},    '{3, 6, 12, 15},   '{9, 12, 18, 21},  '{12, 15, 21, 24}},
    '{'{2, 5, 11, 14},   '{5, 8, 14, 17},   '{11, 14, 20, 23}, '{14, 17, 23, 26}}
  };

  // One face result as it is expected on the output ports.
  typedef struct {
    logic [FaceW-1:0]   face;
    logic [CornerW-1:0] corner [NumCorners];
    logic               last;
  } face_result_t;

  // One row of the directed table. When fixed is set, every corner of
  // every face is expected to equal value, and the predictor is bypassed.
  typedef struct {
    logic [NumNeighbors-1:0] mask;
    logic [63:0]             lo;
    logic [43:0]             hi;
    bit                      fixed;
    logic [CornerW-1:0]      value;
  } voxel_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [NumNeighbors-1:0] solid_mask_i;
  logic [63:0]             shade_low_i;
  logic [43:0]             shade_high_i;
  logic                    out_strobe_o;
  logic [FaceW-1:0]        face_o;
  logic [CornerW-1:0]      corner_a_o;
  logic [CornerW-1:0]      corner_b_o;
  logic [CornerW-1:0]      corner_c_o;
  logic [CornerW-1:0]      corner_d_o;
  logic                    last_face_o;

  face_result_t faces_due [$];
  voxel_row_t   directed_rows [$];
  int           errors;

  voxel_corner_occlusion_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .solid_mask_i (solid_mask_i),
    .shade_low_i  (shade_low_i),
    .shade_high_i (shade_high_i),
    .out_strobe_o (out_strobe_o),
    .face_o       (face_o),
    .corner_a_o   (corner_a_o),
    .corner_b_o   (corner_b_o),
    .corner_c_o   (corner_c_o),
    .corner_d_o   (corner_d_o),
    .last_face_o  (last_face_o)
  );

  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Occlusion value of one corner. Two solid sides shut the corner off
  // completely, so the count is three whatever the corner neighbor holds.
  // Each shade nibble above eight counts as eight, and the sum is clipped
  // to the five-bit range.
  function automatic logic [CornerW-1:0] corner_occlusion(
    input logic [NumNeighbors-1:0] mask,
    input logic [ShadeBits-1:0]    shades,
    input int                      f,
    input int                      c
  );
    logic        at_corner;
    logic        side_a;
    logic        side_b;
    logic [31:0] count;
    logic [31:0] total;
    logic [31:0] nib;
    at_corner = mask[CornerNbr[f][c][0]];
    side_a    = mask[CornerNbr[f][c][1]];
    side_b    = mask[CornerNbr[f][c][2]];
    if (side_a && side_b) begin
      count = 3;
    end else begin
      count = 32'(at_corner) + 32'(side_a) + 32'(side_b);
    end
    total = 8 * count;
    for (int k = 0; k < 4; k++) begin
      nib = 32'(shades[ShadeNbr[f][c][k] * ShadeW +: ShadeW]);
      if (nib > 8) begin
        nib = 8;
      end
      total += nib;
    end
    if (total > 31) begin
      total = 31;
    end
    return total[CornerW-1:0];
  endfunction

  // Pushes the six face results that one accepted neighborhood causes.
  task automatic queue_faces(input voxel_row_t row);
    face_result_t r;
    for (int f = 0; f < NumFaces; f++) begin
      r.face = FaceW'(f);
      for (int c = 0; c < NumCorners; c++) begin
        r.corner[c] = row.fixed ? row.value
                                : corner_occlusion(row.mask, {row.hi, row.lo}, f, c);
      end
      r.last = (f == NumFaces - 1);
      faces_due = {faces_due, r};
    end
  endtask

  // Appends one row to the directed table.
  task automatic add_row(input logic [NumNeighbors-1:0] mask,
                         input logic [63:0] lo, input logic [43:0] hi,
                         input bit fixed, input logic [CornerW-1:0] value);
    voxel_row_t r;
    r.mask  = mask;
    r.lo    = lo;
    r.hi    = hi;
    r.fixed = fixed;
    r.value = value;
    directed_rows = {directed_rows, r};
  endtask

  // Shade vector for all 27 neighbors, each nibble drawn from 0..max_nibble.
  function automatic logic [ShadeBits-1:0] random_shades(input int max_nibble);
    logic [ShadeBits-1:0] v;
    for (int n = 0; n < NumNeighbors; n++) begin
      v[n * ShadeW +: ShadeW] = ShadeW'($urandom_range(0, max_nibble));
    end
    return v;
  endfunction

  // Presents one neighborhood and holds it until the block takes it. Start is
  // left high afterwards; the caller lowers it only when a gap follows. The
  // beat is taken at the first edge where busy, as sampled before the edge,
  // is low.
  task automatic send_voxel(input voxel_row_t row);
    start        <= 1'b1;
    solid_mask_i <= row.mask;
    shade_low_i  <= row.lo;
    shade_high_i <= row.hi;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    queue_faces(row);
  endtask

  // Idles the sender for a number of cycles. Junk is placed on the data ports
  // while start is low, which the block must ignore.
  task automatic idle_sender(input int cycles);
    logic [ShadeBits-1:0] junk;
    logic [31:0]          junk_mask;
    if (cycles > 0) begin
      junk      = random_shades(15);
      junk_mask = $urandom;
      start        <= 1'b0;
      solid_mask_i <= junk_mask[NumNeighbors-1:0];
      shade_low_i  <= junk[63:0];
      shade_high_i <= junk[ShadeBits-1:64];
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Holds the sender off until the last predicted face has come out.
  task automatic drain_faces();
    start <= 1'b0;
    while (faces_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Result checker. The receiver cannot stall, so every strobe is a beat.
  // Outputs are read at the rising edge, before the block updates them.
  always @(posedge clk_i) begin
    face_result_t want;
    if (rst_ni && out_strobe_o === 1'b1) begin
      if (faces_due.size() == 0) begin
        $error("unexpected result beat: face %0d", face_o);
        errors++;
      end else begin
        want = faces_due.pop_front();
        check_field("face",      8'(want.face),      8'(face_o));
        check_field("corner_a",  8'(want.corner[0]), 8'(corner_a_o));
        check_field("corner_b",  8'(want.corner[1]), 8'(corner_b_o));
        check_field("corner_c",  8'(want.corner[2]), 8'(corner_c_o));
        check_field("corner_d",  8'(want.corner[3]), 8'(corner_d_o));
        check_field("last_face", 8'(want.last),      8'(last_face_o));
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    voxel_row_t           row;
    logic [ShadeBits-1:0] shades;
    logic [31:0]          draw;
    int                   burst_left;
    int                   mode;

    errors       = 0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    solid_mask_i = '0;
    shade_low_i  = '0;
    shade_high_i = '0;

    // Rows whose result is obvious are typed in. With no solid neighbor and
    // uniform shades s, each corner is 4*min(s,8), clipped at 31. A fully
    // solid neighborhood adds 24 to that.
    add_row(27'h0000000, 64'h0, 44'h0, 1'b1, 5'd0);
    add_row(27'h7FFFFFF, 64'h0, 44'h0, 1'b1, 5'd24);
    add_row(27'h0000000, 64'hFFFF_FFFF_FFFF_FFFF, 44'hFFF_FFFF_FFFF, 1'b1, 5'd31);
    add_row(27'h0000000, 64'h1111_1111_1111_1111, 44'h111_1111_1111, 1'b1, 5'd4);
    add_row(27'h0000000, 64'h7777_7777_7777_7777, 44'h777_7777_7777, 1'b1, 5'd28);
    add_row(27'h0000000, 64'h8888_8888_8888_8888, 44'h888_8888_8888, 1'b1, 5'd31);
    add_row(27'h7FFFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 44'hFFF_FFFF_FFFF, 1'b1, 5'd31);
    add_row(27'h7FFFFFF, 64'h1111_1111_1111_1111, 44'h111_1111_1111, 1'b1, 5'd28);
    add_row(27'h7FFFFFF, 64'h9999_9999_9999_9999, 44'h999_9999_9999, 1'b1, 5'd31);
    // A single bright nibble: clamping shows without saturation.
    add_row(27'h0000000, 64'h0000_0000_000F_0000, 44'h0, 1'b0, 5'd0);
    add_row(27'h0000000, 64'h0000_0000_0009_0000, 44'h000_0000_000A, 1'b0, 5'd0);
    // Odd neighbors only: both sides solid, corner empty.
    add_row(27'h2AAAAAA, 64'h0, 44'h0, 1'b0, 5'd0);
    add_row(27'h2AAAAAA, 64'h1111_1111_1111_1111, 44'h111_1111_1111, 1'b0, 5'd0);
    // Even neighbors only, and the eight cube corners only.
    add_row(27'h5555555, 64'h0, 44'h0, 1'b0, 5'd0);
    add_row(27'h5555555, 64'h2222_2222_2222_2222, 44'h222_2222_2222, 1'b0, 5'd0);
    add_row(27'h5140145, 64'h0, 44'h0, 1'b0, 5'd0);
    // One side only, single bits at both ends with ramp shades, then all but bit 0.
    add_row(27'h0000002, 64'h0, 44'h0, 1'b0, 5'd0);
    add_row(27'h0000001, 64'h0123_4567_89AB_CDEF, 44'h123_4567_89AB, 1'b0, 5'd0);
    add_row(27'h4000000, 64'hFEDC_BA98_7654_3210, 44'hBA9_8765_4321, 1'b0, 5'd0);
    add_row(27'h7FFFFFE, 64'h0000_1000_0200_0030, 44'h004_0000_5000, 1'b0, 5'd0);

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: back to back for the most part, with an occasional gap.
    foreach (directed_rows[i]) begin
      send_voxel(directed_rows[i]);
      if ($urandom_range(0, 3) == 0) begin
        idle_sender($urandom_range(1, 7));
      end
    end
    drain_faces();

    // Random part. Fully random shades saturate nearly every corner, so most
    // beats use dim shades, and the masks are often sparse or dense to reach
    // the cases where zero, one, two or three neighbors are solid.
    burst_left = 0;
    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 2) begin
        drain_faces();
      end
      if (burst_left == 0) begin
        // Random gaps, sometimes none, land on every phase of the walk through the six faces.
        idle_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 11));
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;

      mode = $urandom_range(0, 9);
      draw = $urandom;
      case (mode)
        0, 1: begin
          shades   = random_shades(15);
          row.mask = draw[NumNeighbors-1:0];
        end
        2, 3, 4: begin
          shades   = random_shades(2);
          row.mask = draw[NumNeighbors-1:0];
        end
        5, 6: begin
          shades   = random_shades(4);
          row.mask = draw[NumNeighbors-1:0] & 27'($urandom);
        end
        7, 8: begin
          shades   = random_shades(1);
          row.mask = draw[NumNeighbors-1:0] | 27'($urandom);
        end
        default: begin
          // Mostly dark, with a few nibbles anywhere in 0..15.
          shades = '0;
          repeat (3) begin
            shades[$urandom_range(0, NumNeighbors - 1) * ShadeW +: ShadeW] =
              ShadeW'($urandom_range(0, 15));
          end
          row.mask = draw[NumNeighbors-1:0];
        end
      endcase
      row.lo    = shades[63:0];
      row.hi    = shades[ShadeBits-1:64];
      row.fixed = 1'b0;
      row.value = '0;
      send_voxel(row);
    end

    drain_faces();
    repeat (SettleCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: a hang in the handshake or a lost result ends here.
  initial begin
    #(TimeoutNs);
    $display("Verification failed");
    $finish;
  end

endmodule
